[src/vipp_pkg.sv]
// Shared types and constants for the variable-integral PID / PWM block.
// No dependencies; every other file in src imports this package.
package vipp_pkg;

	localparam int FRAC_BITS = 8;

	// stream widths
	localparam int IN_W  = 56;
	localparam int OUT_W = 40;

	// fixed-point constants
	localparam logic [17:0] ONE_Q = 18'(1 << FRAC_BITS);
	localparam logic [17:0] TWO_Q = 18'(2 << FRAC_BITS);
	localparam logic [8:0]  W_FULL = 9'd256;
	localparam int LIM_RAW = ((800 << FRAC_BITS) > 262143) ? 262143 : (800 << FRAC_BITS);
	localparam logic signed [19:0] LIM_POS = 20'(LIM_RAW);
	localparam logic signed [19:0] LIM_NEG = -20'(LIM_RAW);

	// datapath widths
	localparam int PD_SH  = 2 * FRAC_BITS;
	localparam int I_SH   = 2 * FRAC_BITS + 8;
	localparam int PS_W   = 43;
	localparam int PD_W   = PS_W - PD_SH;
	localparam int WI_W   = 28;
	localparam int T_W    = 53;
	localparam int TOT_W  = 54;
	localparam int SUM_W  = TOT_W - I_SH;

	// duty limits
	localparam int DUTY_NEUTRAL = 5000;
	localparam int DUTY_MAX     = 9950;
	localparam int DUTY_MIN     = 50;

	// queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// register indexes
	localparam logic [1:0] REG_LOCK   = 2'd0;
	localparam logic [1:0] REG_GAIN_P = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;
	localparam logic [1:0] REG_GAIN_I = 2'd3;

	typedef struct packed {
		logic signed [15:0] e;
		logic signed [16:0] de;
		logic [8:0]         w;
		logic signed [18:0] integ;
		logic signed [18:0] nint;
	} item_t;

	typedef struct packed {
		logic        lock;
		logic [23:0] gain_p;
		logic [23:0] gain_d;
		logic [23:0] gain_i;
	} gains_t;

endpackage

[src/vipp_front.sv]
// Front end: takes input words, computes the integral weight, the error
// difference and the updated integral. Depends on vipp_pkg.
module vipp_front (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [vipp_pkg::IN_W-1:0] s_tdata,
	input  logic                   q_full,
	output logic                   push,
	output vipp_pkg::item_t        push_item
);
	import vipp_pkg::*;

	logic signed [15:0] e;
	logic signed [15:0] ep;
	logic signed [18:0] integ;
	logic signed [16:0] e_x;
	logic [16:0]        mag;
	logic [17:0]        mag_x;
	logic [17:0]        diff;
	logic [25:0]        w_wide;
	logic signed [19:0] nsum;
	logic signed [19:0] nclamp;

	assign e     = s_tdata[15:0];
	assign ep    = s_tdata[31:16];
	assign integ = s_tdata[50:32];

	assign e_x    = {e[15], e};
	assign mag    = e_x[16] ? 17'(-e_x) : 17'(e_x);
	assign mag_x  = {1'b0, mag};
	assign diff   = TWO_Q - mag_x;
	assign w_wide = {diff, 8'b0} >> FRAC_BITS;

	assign nsum = 20'(integ) + 20'(e);

	always_comb begin
		if (nsum >= LIM_POS) begin
			nclamp = LIM_POS;
		end else if (nsum <= LIM_NEG) begin
			nclamp = LIM_NEG;
		end else begin
			nclamp = nsum;
		end
	end

	always_comb begin
		push_item.e     = e;
		push_item.de    = 17'(e) - 17'(ep);
		push_item.integ = integ;
		if (mag_x >= TWO_Q) begin
			push_item.w    = '0;
			push_item.nint = '0;
		end else begin
			push_item.w    = (mag_x <= ONE_Q) ? W_FULL : w_wide[8:0];
			push_item.nint = nclamp[18:0];
		end
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

endmodule

[src/vipp_fifo.sv]
// Short register queue between front and back ends.
// Depends on vipp_pkg for the item type and depth.
module vipp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vipp_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output vipp_pkg::item_t head
);
	import vipp_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_pop;

	assign full   = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/vipp_back.sv]
// Back end: multiply pipeline for the PD and weighted I terms, truncation,
// saturation and the output register. Depends on vipp_pkg.
module vipp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vipp_pkg::gains_t           gains,
	input  logic                       q_valid,
	input  vipp_pkg::item_t            q_item,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [vipp_pkg::OUT_W-1:0] m_tdata
);
	import vipp_pkg::*;

	localparam logic [PS_W-1:0]  PD_BIAS = PS_W'((64'd1 << PD_SH) - 64'd1);
	localparam logic [TOT_W-1:0] I_BIAS  = TOT_W'((64'd1 << I_SH) - 64'd1);
	localparam logic signed [SUM_W-1:0] HI_KNEE = SUM_W'(DUTY_MAX - DUTY_NEUTRAL);
	localparam logic signed [SUM_W-1:0] LO_KNEE = SUM_W'(DUTY_MIN - DUTY_NEUTRAL);

	logic adv;

	logic               v_s1, v_s2, v_s3;
	logic signed [40:0] prod_p_s1;
	logic signed [41:0] prod_d_s1;
	logic signed [WI_W-1:0] wi_s1;
	logic signed [18:0] nint_s1, nint_s2, nint_s3;
	logic signed [PD_W-1:0] pd_s2;
	logic signed [T_W-1:0]  t_s2;
	logic signed [TOT_W-1:0] total_s3;

	logic               out_valid_q;
	logic [13:0]        duty_q;
	logic signed [18:0] nint_q;

	logic signed [PS_W-1:0]  psum;
	logic signed [PS_W-1:0]  pbias;
	logic signed [PS_W-1:0]  pshift;
	logic signed [TOT_W-1:0] pd_x;
	logic signed [TOT_W-1:0] tbias;
	logic signed [TOT_W-1:0] tshift;
	logic signed [SUM_W-1:0] sum;
	logic [13:0]        duty_n;

	// the whole pipe moves while the output register is free or drained
	assign adv = !out_valid_q || m_tready;
	assign pop = adv && q_valid;

	// stage 2: PD sum, truncated toward zero to an integer
	assign psum   = PS_W'(prod_p_s1) + PS_W'(prod_d_s1);
	assign pbias  = psum[PS_W-1] ? (psum + $signed(PD_BIAS)) : psum;
	assign pshift = pbias >>> PD_SH;

	// stage 4: total truncated toward zero, then saturate and offset
	assign pd_x   = {{(TOT_W-PD_W){pd_s2[PD_W-1]}}, pd_s2};
	assign tbias  = total_s3[TOT_W-1] ? (total_s3 + $signed(I_BIAS)) : total_s3;
	assign tshift = tbias >>> I_SH;
	assign sum    = tshift[SUM_W-1:0];

	always_comb begin
		if (gains.lock) begin
			duty_n = 14'(DUTY_NEUTRAL);
		end else if (sum >= HI_KNEE) begin
			duty_n = 14'(DUTY_MAX);
		end else if (sum <= LO_KNEE) begin
			duty_n = 14'(DUTY_MIN);
		end else begin
			duty_n = 14'(sum + SUM_W'(DUTY_NEUTRAL));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_p_s1 <= q_item.e * $signed({1'b0, gains.gain_p});
			prod_d_s1 <= q_item.de * $signed({1'b0, gains.gain_d});
			wi_s1     <= $signed({1'b0, q_item.w}) * q_item.integ;
			nint_s1   <= q_item.nint;

			pd_s2   <= pshift[PD_W-1:0];
			t_s2    <= wi_s1 * $signed({1'b0, gains.gain_i});
			nint_s2 <= nint_s1;

			total_s3 <= (pd_x <<< I_SH) + TOT_W'(t_s2);
			nint_s3  <= nint_s2;

			duty_q <= duty_n;
			nint_q <= nint_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, nint_q, duty_q};

endmodule

[src/variable_integral_pid_pwm.sv]
// Top level of the variable-integral PID / PWM block: register port,
// front end, queue and back-end pipeline. Depends on vipp_pkg and submodules.
//
//  channel  direction  handshake                     payload
//  s_*      in         s_tvalid / s_tready           error, prev_error, integral_in
//  m_*      out        m_tvalid / m_tready           duty, integral_out
//  apb      in         psel, penable, pwrite, pready lock, gain_p, gain_d, gain_i
//
// One word per cycle in and out while m_* is ready; an accepted word passes
// through the queue and the back-end multiply pipeline (three stages plus the
// output register) to m_*. A stall on m_* freezes the pipeline while the four-entry
// queue keeps taking words until it fills. Reset clears the registers to 0
// and empties the queue and pipeline.
module variable_integral_pid_pwm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // error[15:0], prev_error[31:16], integral_in[50:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // duty[13:0], integral_out[32:14]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vipp_pkg::*;

	gains_t gains_q;
	logic   wr_en;
	logic   push;
	logic   q_full;
	logic   q_valid;
	logic   pop;
	item_t  push_item;
	item_t  q_item;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_LOCK:   gains_q.lock   <= pwdata[0];
				REG_GAIN_P: gains_q.gain_p <= pwdata[23:0];
				REG_GAIN_D: gains_q.gain_d <= pwdata[23:0];
				REG_GAIN_I: gains_q.gain_i <= pwdata[23:0];
				default:    gains_q        <= gains_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LOCK:   prdata = {31'b0, gains_q.lock};
			REG_GAIN_P: prdata = {8'b0, gains_q.gain_p};
			REG_GAIN_D: prdata = {8'b0, gains_q.gain_d};
			REG_GAIN_I: prdata = {8'b0, gains_q.gain_i};
			default:    prdata = '0;
		endcase
	end

	vipp_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	vipp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (q_item)
	);

	vipp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[tb/sv/tb.sv]
// Stream-level testbench for variable_integral_pid_pwm: random and directed
// error samples, APB gain writes, and an in-bench predictor of duty and integral.
// Depends on vipp_pkg and the RTL of the block.
module tb;
	import vipp_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLDOFF_CYCLES = 60;
	localparam int MAX_PRINTED    = 40;

	typedef struct packed {
		logic signed [18:0] integral_in;
		logic signed [15:0] prev_error;
		logic signed [15:0] error;
	} sample_t;

	typedef struct packed {
		logic signed [18:0] integral_out;
		logic [13:0]        duty;
	} pid_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // error[15:0], prev_error[31:16], integral_in[50:32]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // duty[13:0], integral_out[32:14]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// controller settings as last written
	logic   cfg_lock = 1'b0;
	longint cfg_gain_p = 0;
	longint cfg_gain_d = 0;
	longint cfg_gain_i = 0;

	sample_t     sample_queue[$];
	pid_result_t expected_outputs[$];
	int          mismatch_count = 0;
	logic        s_taken = 1'b0;
	logic        steady = 1'b0;
	int          holdoff_req = 0;
	int          holdoff_seen = 0;
	int          holdoff_left = 0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          quiet_cycles = 0;

	variable_integral_pid_pwm u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	function automatic longint shift_toward_zero(longint x, int s);
		if (x < 0)
			return -((-x) >>> s);
		return x >>> s;
	endfunction

	function automatic pid_result_t compute_pid(sample_t smp);
		longint err, prev, integ, mag, one_q, two_q, weight, pd, total, sum, lim, nint;
		pid_result_t r;
		err   = smp.error;
		prev  = smp.prev_error;
		integ = smp.integral_in;
		one_q = 64'sd1 <<< FRAC_BITS;
		two_q = 64'sd2 <<< FRAC_BITS;
		mag   = (err < 0) ? -err : err;

		pd = shift_toward_zero(err * cfg_gain_p + (err - prev) * cfg_gain_d, 2 * FRAC_BITS);

		// weight in Q1.8: full inside one degree, none beyond two
		if (mag >= two_q)
			weight = 0;
		else if (mag <= one_q)
			weight = 256;
		else
			weight = ((two_q - mag) * 256) >>> FRAC_BITS;

		total = pd * (64'sd1 <<< (2 * FRAC_BITS + 8)) + cfg_gain_i * weight * integ;
		sum = shift_toward_zero(total, 2 * FRAC_BITS + 8);
		if (sum >= 4999)
			sum = 4999;
		else if (sum <= -5000)
			sum = -5000;
		sum = sum + 5000;
		if (sum > 9950)
			sum = 9950;
		if (sum < 50)
			sum = 50;
		r.duty = cfg_lock ? 14'd5000 : 14'(sum);

		lim = 64'sd800 <<< FRAC_BITS;
		if (lim > 262143)
			lim = 262143;
		if (mag < two_q) begin
			nint = integ + err;
			if (nint >= lim)
				nint = lim;
			else if (nint <= -lim)
				nint = -lim;
		end else begin
			nint = 0;
		end
		r.integral_out = 19'(nint);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (index)
			REG_LOCK:   cfg_lock = value[0];
			REG_GAIN_P: cfg_gain_p = longint'(value[23:0]);
			REG_GAIN_D: cfg_gain_d = longint'(value[23:0]);
			REG_GAIN_I: cfg_gain_i = longint'(value[23:0]);
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_settings(logic lock, logic [23:0] gp, logic [23:0] gd, logic [23:0] gi);
		write_register(REG_LOCK, {31'd0, lock});
		write_register(REG_GAIN_P, {8'd0, gp});
		write_register(REG_GAIN_D, {8'd0, gd});
		write_register(REG_GAIN_I, {8'd0, gi});
	endtask

	task automatic wait_drained();
		while (sample_queue.size() != 0 || expected_outputs.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_sample(int err, int prev, int integ);
		sample_t smp;
		smp.error       = 16'(err);
		smp.prev_error  = 16'(prev);
		smp.integral_in = 19'(integ);
		sample_queue.push_back(smp);
	endtask

	function automatic logic [23:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom());
			default: return 24'($urandom_range(0, 1 << 17));
		endcase
	endfunction

	function automatic int near_threshold();
		int mag;
		case ($urandom_range(0, 6))
			0: mag = 255;
			1: mag = 256;
			2: mag = 257;
			3: mag = 384;
			4: mag = 511;
			5: mag = 512;
			default: mag = 513;
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	task automatic push_random_sample();
		int err, prev, integ;
		case ($urandom_range(0, 3))
			0: err = int'($urandom());
			1: err = int'($urandom_range(0, 1200)) - 600;
			2: err = near_threshold();
			default: err = int'($urandom_range(0, 128)) - 64;
		endcase
		if ($urandom_range(0, 1))
			prev = err + int'($urandom_range(0, 600)) - 300;
		else
			prev = int'($urandom());
		case ($urandom_range(0, 3))
			0: integ = int'($urandom());
			1: integ = int'($urandom_range(0, 409600)) - 204800;
			2: begin
				integ = 204800 - int'($urandom_range(0, 600));
				if ($urandom_range(0, 1))
					integ = -integ;
			end
			default: integ = int'($urandom_range(0, 4000)) - 2000;
		endcase
		push_sample(err, prev, integ);
	endtask

	// sender: hold an offered word until taken, else idle in bursts or offer the next
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_taken) begin
		end else if (send_gap > 0) begin
			send_gap--;
			s_tvalid <= 1'b0;
		end else if (!steady && $urandom_range(0, 9) == 0) begin
			send_gap = $urandom_range(0, 6);
			s_tvalid <= 1'b0;
		end else if (sample_queue.size() != 0) begin
			s_tvalid <= 1'b1;
			s_tdata  <= {5'd0, sample_queue[0]};
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver: long hold-off on request, else random stall bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else if (holdoff_req != holdoff_seen) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 7) == 0) begin
			recv_stall = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// capture accepted words on both sides
	always @(posedge clk) begin
		pid_result_t want;
		if (!arst_n) begin
			s_taken <= 1'b0;
		end else begin
			s_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				expected_outputs.push_back(compute_pid(sample_t'(s_tdata[50:0])));
				sample_queue.pop_front();
			end
			if (m_tvalid && m_tready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("unexpected word, duty", m_tdata[13:0], -1);
				end else begin
					want = expected_outputs.pop_front();
					if (m_tdata[13:0] !== want.duty)
						report_mismatch("duty", m_tdata[13:0], want.duty);
					if (m_tdata[32:14] !== want.integral_out)
						report_mismatch("integral_out", $signed(m_tdata[32:14]),
							want.integral_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int k, phase;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: unit P and I gains, half D gain, around the weight thresholds and integral limits
		apply_settings(1'b0, 24'h000100, 24'h000080, 24'h000100);
		push_sample(0, 0, 0);
		push_sample(32767, -32768, 0);
		push_sample(-32768, 32767, 0);
		push_sample(0, 32767, 0);
		push_sample(256, 0, 1000);
		push_sample(-256, 0, -1000);
		push_sample(257, 200, 5000);
		push_sample(-257, -300, -5000);
		push_sample(384, 384, 20000);
		push_sample(-384, 0, -20000);
		push_sample(511, 0, 204800);
		push_sample(-511, 0, -204800);
		push_sample(512, 0, 12345);
		push_sample(-512, 0, 999);
		push_sample(513, 0, -999);
		push_sample(200, 0, 204700);
		push_sample(-200, 0, -204700);
		push_sample(100, 0, 262143);
		push_sample(-100, 0, -262144);
		push_sample(0, 0, 204800);
		wait_drained();

		// full-scale gains: saturate both duty rails
		apply_settings(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		push_sample(32767, -32768, 262143);
		push_sample(-32768, 32767, -262144);
		push_sample(1, 0, 1);
		push_sample(-1, 0, -1);
		for (k = 0; k < 200; k++)
			push_random_sample();
		wait_drained();

		// locked output, with a long receiver hold-off to back up the queue
		apply_settings(1'b1, pick_gain(), pick_gain(), pick_gain());
		for (k = 0; k < 300; k++)
			push_random_sample();
		holdoff_req++;
		wait_drained();

		apply_settings(1'b0, 24'd0, 24'd0, 24'd0);
		for (k = 0; k < 200; k++)
			push_random_sample();
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			apply_settings(1'($urandom_range(0, 3) == 0), pick_gain(), pick_gain(), pick_gain());
			for (k = 0; k < 300; k++)
				push_random_sample();
			wait_drained();
		end

		// closing stretch at full rate on both sides
		steady = 1'b1;
		apply_settings(1'b0, pick_gain(), pick_gain(), pick_gain());
		for (k = 0; k < 200; k++)
			push_random_sample();
		wait_drained();
		repeat (20) @(posedge clk);

		if (expected_outputs.size() != 0)
			report_mismatch("words never delivered", 0, expected_outputs.size());
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[variable_integral_pid_pwm.f]
src/vipp_pkg.sv
src/vipp_front.sv
src/vipp_fifo.sv
src/vipp_back.sv
src/variable_integral_pid_pwm.sv
tb/sv/tb.sv
